/* src/vsp_pkg.sv */
// Package for the version string parser: character codes, stage codes
// and the decimal weights of the packed version code. No dependencies.
`default_nettype none

package vsp_pkg;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_F     = 8'h66;

    // Stage codes as they appear in the packed code.
    localparam logic [3:0] STAGE_NONE      = 4'd0;
    localparam logic [3:0] STAGE_DEV       = 4'd1;
    localparam logic [3:0] STAGE_ALPHA     = 4'd3;
    localparam logic [3:0] STAGE_BETA      = 4'd5;
    localparam logic [3:0] STAGE_CANDIDATE = 4'd7;
    localparam logic [3:0] STAGE_RELEASE   = 4'd9;

    // Field weights and limits.
    localparam logic [39:0] SCALE_MAJOR    = 40'd100000000;
    localparam logic [26:0] SCALE_MINOR    = 27'd1000000;
    localparam logic [19:0] SCALE_REVISION = 20'd10000;
    localparam logic [13:0] SCALE_STAGE    = 14'd1000;
    localparam logic [9:0]  LEVEL_MAX      = 10'd255;
    localparam logic [39:0] CODE_MAX       = 40'd999999999255;

endpackage

`default_nettype wire

/* src/version_string_parser.sv */
// Version string parser: one character per transfer, one result per NUL.
// Result path: fields go through snapshot, product and output registers.
// Throughput: one character per cycle; characters keep flowing while a
// result waits, and the pipe stalls only when a NUL meets three results
// still queued in the result stages.
// Reset: asynchronous, active low; parser returns to the start of string.
// Depends on vsp_pkg.
`default_nettype none

module version_string_parser
    import vsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok,
    output logic [39:0]      code
);

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_MAJOR     = 4'd1,
        PH_MINOR     = 4'd2,
        PH_REV       = 4'd3,
        PH_RELSTATE  = 4'd4,
        PH_F_SEEN    = 4'd5,
        PH_STAGE_DIG = 4'd6,
        PH_LEVEL     = 4'd7,
        PH_DONE      = 4'd8
    } phase_t;

    // Input register.
    logic        ch_valid_reg;
    logic [7:0]  ch_reg;

    // Parser state.
    phase_t      phase_reg,    phase_next;
    logic [1:0]  count_reg,    count_next;
    logic [13:0] major_reg,    major_next;
    logic [6:0]  minor_reg,    minor_next;
    logic [6:0]  revision_reg, revision_next;
    logic [3:0]  stage_reg,    stage_next;
    logic [9:0]  level_reg,    level_next;
    logic        failed_reg,   failed_next;
    logic        ok_next;

    // Snapshot stage, product stage.
    logic        a_valid_reg, a_ok_reg;
    logic [13:0] a_major_reg;
    logic [6:0]  a_minor_reg, a_revision_reg;
    logic [3:0]  a_stage_reg;
    logic [9:0]  a_level_reg;
    logic        b_valid_reg, b_ok_reg;
    logic [39:0] b_major_reg;
    logic [26:0] b_minor_reg;
    logic [19:0] b_revision_reg;
    logic [13:0] b_low_reg;

    logic        ok_reg;
    logic [39:0] code_reg;
    logic        out_valid_reg;

    // Character classes.
    logic       is_nul, is_dig, is_end, is_let;
    logic [7:0] dig_full;
    logic [3:0] dig;

    assign is_nul   = (ch_reg == CH_NUL);
    assign is_dig   = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_end   = is_nul || (ch_reg == CH_SPACE) || (ch_reg == CH_TAB)
                   || (ch_reg == CH_CR) || (ch_reg == CH_LF);
    assign is_let   = (ch_reg == CH_D) || (ch_reg == CH_A) || (ch_reg == CH_B)
                   || (ch_reg == CH_F);
    assign dig_full = ch_reg - CH_ZERO;
    assign dig      = dig_full[3:0];

    // Handshake chain through the stages.
    logic out_free, o_take, b_free, b_take, a_free, consume;

    assign out_free = !out_valid_reg || out_ready;
    assign o_take   = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || o_take;
    assign b_take   = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || b_take;
    assign consume  = ch_valid_reg && (!is_nul || a_free);
    assign in_ready = !ch_valid_reg || consume;

    // One character update. A character falls through on a full field, a
    // letter after a number or a level digit: up to three phases see it.
    always_comb
    begin
        logic go;
        phase_next    = phase_reg;
        count_next    = count_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        revision_next = revision_reg;
        stage_next    = stage_reg;
        level_next    = level_reg;
        failed_next   = failed_reg;
        go            = !failed_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (go)
            begin
                go = 1'b0;
                unique case (phase_next)
                    PH_START:
                    begin
                        if (is_dig)
                        begin
                            major_next = {10'd0, dig};
                            count_next = 2'd0;
                            phase_next = PH_MAJOR;
                        end
                        else
                            failed_next = 1'b1;
                    end
                    PH_MAJOR:
                    begin
                        if (count_next != 2'd3)
                        begin
                            priority if (is_end)
                            begin
                                stage_next = STAGE_RELEASE;
                                level_next = 10'd0;
                                phase_next = PH_DONE;
                            end
                            else if (is_dig)
                            begin
                                major_next = major_next * 14'd10 + {10'd0, dig};
                                count_next = count_next + 2'd1;
                            end
                            else if (is_let)
                            begin
                                phase_next = PH_RELSTATE;
                                go = 1'b1;
                            end
                            else if (ch_reg == CH_DOT)
                            begin
                                phase_next = PH_MINOR;
                                count_next = 2'd0;
                            end
                            else
                                failed_next = 1'b1;
                        end
                        else if (ch_reg == CH_DOT)
                        begin
                            phase_next = PH_MINOR;
                            count_next = 2'd0;
                        end
                        else if (is_dig)
                            failed_next = 1'b1;
                        else
                        begin
                            phase_next = PH_MINOR;
                            count_next = 2'd0;
                            go = 1'b1;
                        end
                    end
                    PH_MINOR:
                    begin
                        if (count_next < 2'd2)
                        begin
                            priority if (is_end)
                            begin
                                stage_next = STAGE_RELEASE;
                                level_next = 10'd0;
                                phase_next = PH_DONE;
                            end
                            else if (is_dig)
                            begin
                                minor_next = minor_next * 7'd10 + {3'd0, dig};
                                count_next = count_next + 2'd1;
                            end
                            else if (is_let)
                            begin
                                phase_next = PH_RELSTATE;
                                go = 1'b1;
                            end
                            else if (ch_reg == CH_DOT)
                            begin
                                phase_next = PH_REV;
                                count_next = 2'd0;
                            end
                            else
                                failed_next = 1'b1;
                        end
                        else if (ch_reg == CH_DOT)
                        begin
                            phase_next = PH_REV;
                            count_next = 2'd0;
                        end
                        else if (is_dig)
                            failed_next = 1'b1;
                        else
                        begin
                            phase_next = PH_REV;
                            count_next = 2'd0;
                            go = 1'b1;
                        end
                    end
                    PH_REV:
                    begin
                        if (count_next < 2'd2)
                        begin
                            priority if (is_end)
                            begin
                                stage_next = STAGE_RELEASE;
                                level_next = 10'd0;
                                phase_next = PH_DONE;
                            end
                            else if (is_dig)
                            begin
                                revision_next = revision_next * 7'd10 + {3'd0, dig};
                                count_next    = count_next + 2'd1;
                            end
                            else if (is_let)
                            begin
                                phase_next = PH_RELSTATE;
                                go = 1'b1;
                            end
                            else
                                failed_next = 1'b1;
                        end
                        else if (ch_reg == CH_DOT)
                            phase_next = PH_RELSTATE;
                        else if (is_dig)
                            failed_next = 1'b1;
                        else
                        begin
                            phase_next = PH_RELSTATE;
                            go = 1'b1;
                        end
                    end
                    PH_RELSTATE:
                    begin
                        priority if (is_end)
                        begin
                            stage_next = STAGE_RELEASE;
                            level_next = 10'd0;
                            phase_next = PH_DONE;
                        end
                        else if (ch_reg == CH_D)
                        begin
                            stage_next = STAGE_DEV;
                            phase_next = PH_STAGE_DIG;
                        end
                        else if (ch_reg == CH_A)
                        begin
                            stage_next = STAGE_ALPHA;
                            phase_next = PH_STAGE_DIG;
                        end
                        else if (ch_reg == CH_B)
                        begin
                            stage_next = STAGE_BETA;
                            phase_next = PH_STAGE_DIG;
                        end
                        else if (ch_reg == CH_F)
                        begin
                            stage_next = STAGE_CANDIDATE;
                            phase_next = PH_F_SEEN;
                        end
                        else
                            failed_next = 1'b1;
                    end
                    PH_F_SEEN:
                    begin
                        priority if (is_dig)
                        begin
                            phase_next = PH_LEVEL;
                            count_next = 2'd0;
                            level_next = 10'd0;
                            go = 1'b1;
                        end
                        else if (ch_reg == CH_C)
                            phase_next = PH_STAGE_DIG;
                        else
                            failed_next = 1'b1;
                    end
                    PH_STAGE_DIG:
                    begin
                        if (is_dig)
                        begin
                            phase_next = PH_LEVEL;
                            count_next = 2'd0;
                            level_next = 10'd0;
                            go = 1'b1;
                        end
                        else
                            failed_next = 1'b1;
                    end
                    PH_LEVEL:
                    begin
                        if (count_next != 2'd3)
                        begin
                            priority if (is_end)
                            begin
                                if (count_next != 2'd0)
                                    phase_next = PH_DONE;
                                else
                                    failed_next = 1'b1;
                            end
                            else if (is_dig)
                            begin
                                level_next = level_next * 10'd10 + {6'd0, dig};
                                count_next = count_next + 2'd1;
                            end
                            else
                                failed_next = 1'b1;
                        end
                        else if (is_end && (level_next <= LEVEL_MAX))
                            phase_next = PH_DONE;
                        else
                            failed_next = 1'b1;
                    end
                    PH_DONE:
                    begin
                    end
                    default:
                        failed_next = 1'b1;
                endcase
            end
        end
        ok_next = !failed_next && (phase_next == PH_DONE)
               && !((stage_next == STAGE_CANDIDATE) && (level_next == 10'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid_reg   <= 1'b0;
            ch_reg         <= CH_NUL;
            phase_reg      <= PH_START;
            count_reg      <= 2'd0;
            major_reg      <= 14'd0;
            minor_reg      <= 7'd0;
            revision_reg   <= 7'd0;
            stage_reg      <= STAGE_NONE;
            level_reg      <= 10'd0;
            failed_reg     <= 1'b0;
            a_valid_reg    <= 1'b0;
            a_ok_reg       <= 1'b0;
            a_major_reg    <= 14'd0;
            a_minor_reg    <= 7'd0;
            a_revision_reg <= 7'd0;
            a_stage_reg    <= STAGE_NONE;
            a_level_reg    <= 10'd0;
            b_valid_reg    <= 1'b0;
            b_ok_reg       <= 1'b0;
            b_major_reg    <= 40'd0;
            b_minor_reg    <= 27'd0;
            b_revision_reg <= 20'd0;
            b_low_reg      <= 14'd0;
            out_valid_reg  <= 1'b0;
            ok_reg         <= 1'b0;
            code_reg       <= 40'd0;
        end
        else
        begin
            if (in_ready)
            begin
                ch_valid_reg <= in_valid;
                ch_reg       <= ch;
            end

            // A NUL hands the finished fields on and restarts the parser.
            if (consume)
            begin
                if (is_nul)
                begin
                    phase_reg      <= PH_START;
                    count_reg      <= 2'd0;
                    major_reg      <= 14'd0;
                    minor_reg      <= 7'd0;
                    revision_reg   <= 7'd0;
                    stage_reg      <= STAGE_NONE;
                    level_reg      <= 10'd0;
                    failed_reg     <= 1'b0;
                    a_ok_reg       <= ok_next;
                    a_major_reg    <= major_next;
                    a_minor_reg    <= minor_next;
                    a_revision_reg <= revision_next;
                    a_stage_reg    <= stage_next;
                    a_level_reg    <= level_next;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    count_reg    <= count_next;
                    major_reg    <= major_next;
                    minor_reg    <= minor_next;
                    revision_reg <= revision_next;
                    stage_reg    <= stage_next;
                    level_reg    <= level_next;
                    failed_reg   <= failed_next;
                end
            end

            if (consume && is_nul)
                a_valid_reg <= 1'b1;
            else if (b_take)
                a_valid_reg <= 1'b0;

            if (b_take)
            begin
                b_ok_reg <= a_ok_reg;
                if (a_ok_reg)
                begin
                    b_major_reg    <= {26'd0, a_major_reg} * SCALE_MAJOR;
                    b_minor_reg    <= {20'd0, a_minor_reg} * SCALE_MINOR;
                    b_revision_reg <= {13'd0, a_revision_reg} * SCALE_REVISION;
                    b_low_reg      <= {10'd0, a_stage_reg} * SCALE_STAGE
                                    + {4'd0, a_level_reg};
                end
                else
                begin
                    b_major_reg    <= 40'd0;
                    b_minor_reg    <= 27'd0;
                    b_revision_reg <= 20'd0;
                    b_low_reg      <= 14'd0;
                end
            end

            if (b_take)
                b_valid_reg <= 1'b1;
            else if (o_take)
                b_valid_reg <= 1'b0;

            if (o_take)
            begin
                out_valid_reg <= 1'b1;
                ok_reg        <= b_ok_reg;
                code_reg      <= b_major_reg + {13'd0, b_minor_reg}
                               + {20'd0, b_revision_reg} + {26'd0, b_low_reg};
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign code      = code_reg;

endmodule

`default_nettype wire

/* src/vsp_checker.sv */
// Port-level checker for version_string_parser, attached by bind.
// Depends on vsp_pkg.
`default_nettype none

module vsp_checker
    import vsp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  ch,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        ok,
    input wire logic [39:0] code
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(code))
        else $error("result changed while stalled");

    // An invalid string always packs to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> code == 40'd0)
        else $error("invalid result carries a nonzero code");

    // A valid version always has a stage code, so its code is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> code != 40'd0 && code <= CODE_MAX)
        else $error("valid result code out of range");

    // With the result side ready, every stage can move, so the input never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while the result side was ready");

endmodule

bind version_string_parser vsp_checker u_vsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .code      (code)
);

`default_nettype wire
